// ===== rtl/ird_pkg.sv =====
// shared types and constants for the ir remote pulse-width decoder
// no dependencies; used by the top level and its checker

package ird_pkg;

    localparam int CODE_W   = 25;
    localparam int KEY_W    = 4;
    localparam int TAP_W    = 8;
    localparam int RUN_W    = 8;
    localparam int HOLD_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int KEY_COUNT = 13;

    localparam logic [KEY_W-1:0] KEY_UNKNOWN = 4'd13;

    localparam logic [RUN_W-1:0]  BIT_THRESHOLD_RST = 8'd4;
    localparam logic [RUN_W-1:0]  IDLE_LIMIT_RST    = 8'd100;
    localparam logic [HOLD_W-1:0] HOLD_PERIOD_RST   = 12'd1500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_THRESHOLD = 2'd0,
        CFG_IDLE_LIMIT    = 2'd1,
        CFG_HOLD_PERIOD   = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_idx_t;

    typedef logic [CODE_W-1:0] code_t;

    // remote code for each key, in key index order
    localparam code_t KEY_CODES [KEY_COUNT] = '{
        25'd11719891, 25'd16961491, 25'd15913171, 25'd15389011, 25'd14864851,
        25'd14340691, 25'd13816531, 25'd13292371, 25'd12768211, 25'd12244051,
        25'd19058131, 25'd8050771,  25'd24823891
    };

    // parallel compare against the key table, first match wins
    function automatic logic [KEY_W-1:0] lookup_key(input code_t code);
        logic [KEY_W-1:0] key;
        key = KEY_UNKNOWN;
        for (int i = KEY_COUNT - 1; i >= 0; i--) begin
            if (KEY_CODES[i] == code) begin
                key = KEY_W'(i);
            end
        end
        return key;
    endfunction

endpackage

// ===== rtl/ir_remote_pulse_width_decoder.sv =====
// ir remote pulse-width decoder: pin samples in, decoded frames out
// depends on ird_pkg (widths, key table, register indexes)
// path: input register then result register; out_valid is set from the result register
//   as the staged sample that ends a frame moves on
// throughput: one pin sample per cycle; stalls only while a finished frame
//   waits in the output register and the next frame also ends
// reset: rst_n async active low, clears decoder state and restores registers
//   to threshold 4, idle limit 100, hold period 1500; no clearing pass

module ir_remote_pulse_width_decoder #(
    parameter int BIT_COUNT = 25
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ird_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ird_pkg::HOLD_W-1:0]  cfg_data,
    // pin sample channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        pin_level,
    // frame result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ird_pkg::CODE_W-1:0]  code_word,
    output logic [ird_pkg::KEY_W-1:0]   key_index,
    output logic [ird_pkg::TAP_W-1:0]   tap_count
);
    import ird_pkg::*;

    // bit counter must hold BIT_COUNT itself
    localparam int IDX_W = $clog2(BIT_COUNT + 1);
    localparam logic [IDX_W-1:0] BIT_LAST = IDX_W'(BIT_COUNT);

    // configuration registers
    logic [RUN_W-1:0]  bit_threshold_reg;
    logic [RUN_W-1:0]  idle_limit_reg;
    logic [HOLD_W-1:0] hold_period_reg;

    // input register stage
    logic s1_valid_reg;
    logic pin_reg;

    // decoder state
    logic              armed_reg,     armed_next;
    logic [RUN_W-1:0]  high_run_reg,  high_run_next;
    logic [IDX_W-1:0]  bit_index_reg, bit_index_next;
    code_t             code_reg,      code_next;
    logic [HOLD_W-1:0] hold_reg,      hold_next;
    logic [TAP_W-1:0]  taps_reg,      taps_next;

    // output register
    logic              out_valid_reg;
    code_t             code_word_reg;
    logic [KEY_W-1:0]  key_index_reg;
    logic [TAP_W-1:0]  tap_count_reg;

    logic              frame_end;
    logic              take_bit;
    logic              code_full;
    logic [RUN_W-1:0]  run_inc;
    logic [HOLD_W-1:0] hold_inc;
    logic [IDX_W-1:0]  idx_after;
    logic              out_free;
    logic              s1_adv;
    logic              s1_fire;

    // registers are always writable; the user must write only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_threshold_reg <= BIT_THRESHOLD_RST;
            idle_limit_reg    <= IDLE_LIMIT_RST;
            hold_period_reg   <= HOLD_PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BIT_THRESHOLD: bit_threshold_reg <= cfg_data[RUN_W-1:0];
                CFG_IDLE_LIMIT:    idle_limit_reg    <= cfg_data[RUN_W-1:0];
                CFG_HOLD_PERIOD:   hold_period_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // output slot frees when empty or taken this cycle
    assign out_free = !out_valid_reg || out_ready;
    // the staged sample moves on unless it ends a frame that has nowhere to go
    assign s1_adv   = !s1_valid_reg || !frame_end || out_free;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_ready = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pin_reg <= pin_level;
        end
    end

    // one tick of the decoder on the staged sample
    always_comb
    begin
        run_inc   = (high_run_reg != {RUN_W{1'b1}}) ? high_run_reg + 1'b1 : high_run_reg;
        frame_end = s1_valid_reg && armed_reg && pin_reg && (run_inc > idle_limit_reg);

        // a low after a high run closes one bit
        take_bit  = armed_reg && !pin_reg && (high_run_reg != '0) && (bit_index_reg < BIT_LAST);
        code_next = code_reg;
        if (take_bit && (high_run_reg >= bit_threshold_reg))
        begin
            // bits past the stored width fall off the shift
            code_next = code_reg | (CODE_W'(1) << bit_index_reg);
        end
        idx_after = take_bit ? bit_index_reg + 1'b1 : bit_index_reg;
        code_full = (idx_after >= BIT_LAST);

        // hold timer runs once the code is complete; period 0 acts as 1
        hold_inc  = hold_reg + 1'b1;
        hold_next = hold_reg;
        taps_next = taps_reg;
        if (code_full)
        begin
            hold_next = hold_inc;
            if (hold_inc >= hold_period_reg)
            begin
                hold_next = '0;
                if (taps_reg != {TAP_W{1'b1}})
                begin
                    taps_next = taps_reg + 1'b1;
                end
            end
        end

        armed_next     = armed_reg;
        high_run_next  = high_run_reg;
        bit_index_next = idx_after;
        if (!pin_reg)
        begin
            armed_next    = 1'b1;
            high_run_next = '0;
        end
        else if (armed_reg)
        begin
            high_run_next = run_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            high_run_reg  <= '0;
            bit_index_reg <= '0;
            code_reg      <= '0;
            hold_reg      <= '0;
            taps_reg      <= '0;
        end
        else if (s1_fire)
        begin
            if (frame_end)
            begin
                // frame done, start over
                armed_reg     <= 1'b0;
                high_run_reg  <= '0;
                bit_index_reg <= '0;
                code_reg      <= '0;
                hold_reg      <= '0;
                taps_reg      <= '0;
            end
            else
            begin
                armed_reg     <= armed_next;
                high_run_reg  <= high_run_next;
                bit_index_reg <= bit_index_next;
                code_reg      <= code_next;
                hold_reg      <= hold_next;
                taps_reg      <= taps_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && frame_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && frame_end)
        begin
            code_word_reg <= code_next;
            key_index_reg <= lookup_key(code_next);
            tap_count_reg <= taps_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign code_word = code_word_reg;
    assign key_index = key_index_reg;
    assign tap_count = tap_count_reg;

endmodule

// ===== rtl/ird_checker.sv =====
// port-level checks for the ir remote pulse-width decoder
// depends on ird_pkg; bound to ir_remote_pulse_width_decoder below

module ird_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_ready,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [ird_pkg::CODE_W-1:0]   code_word,
    input logic [ird_pkg::KEY_W-1:0]    key_index,
    input logic [ird_pkg::TAP_W-1:0]    tap_count
);
    import ird_pkg::*;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_word)
            && $stable(key_index) && $stable(tap_count))
        else $error("result changed while stalled");

    // an empty output slot never blocks the sample channel
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // key index stays within the defined keys or KEY_UNKNOWN
    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_index <= KEY_UNKNOWN)
        else $error("key index out of range");

    // a known key always carries its table code
    a_key_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_index != KEY_UNKNOWN |-> code_word == KEY_CODES[key_index])
        else $error("key index does not match code");

    // register port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind ir_remote_pulse_width_decoder ird_checker u_ird_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_word (code_word),
    .key_index (key_index),
    .tap_count (tap_count)
);
